// ===== rtl/kpsb_pkg.sv =====
// Shared types and constants for the keyed packet slot buffer.
`default_nettype none

package kpsb_pkg;

    localparam int SLOT_COUNT = 16;

    localparam int SEQ_W   = 16;
    localparam int FLAGS_W = 9;

    localparam logic [SEQ_W-1:0]   SEQ_EMPTY = '1;
    localparam logic [FLAGS_W-1:0] FLAGS_ANY = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [15:0] ident;
        logic [15:0] window;
        logic [31:0] check;
        logic [15:0] length;
        logic [15:0] handle;
    } t_hdr;

    // Command word that walks the cell row; done marks an insert placed or a find hit.
    typedef struct packed {
        t_cmd               cmd;
        logic [SEQ_W-1:0]   seq;
        logic [FLAGS_W-1:0] flags;
        t_hdr               hdr;
        logic               done;
    } t_probe;

endpackage

`default_nettype wire

// ===== rtl/kpsb_cell.sv =====
// One slot of the buffer: holds a header and acts on the command word passing through.
`default_nettype none

module kpsb_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire kpsb_pkg::t_probe i_probe,
    output logic                 o_valid,
    output kpsb_pkg::t_probe     o_probe
);

    logic [kpsb_pkg::SEQ_W-1:0]   r_seq;
    logic [kpsb_pkg::SEQ_W-1:0]   n_seq;
    logic [kpsb_pkg::FLAGS_W-1:0] r_flags;
    kpsb_pkg::t_hdr               r_hdr;
    logic                         r_valid;
    kpsb_pkg::t_probe             r_probe;
    kpsb_pkg::t_probe             n_probe;
    logic                         wr_en;
    logic                         occupied;
    logic                         hit;

    assign occupied = (r_seq != kpsb_pkg::SEQ_EMPTY);

    // A flags search sees only occupied slots; with neither key a wildcard, a find never hits.
    always_comb begin
        if (i_probe.seq == kpsb_pkg::SEQ_EMPTY) begin
            hit = occupied && (r_flags == i_probe.flags);
        end else if (i_probe.flags == kpsb_pkg::FLAGS_ANY) begin
            hit = (r_seq == i_probe.seq);
        end else begin
            hit = 1'b0;
        end
    end

    always_comb begin
        n_probe = i_probe;
        n_seq   = r_seq;
        wr_en   = 1'b0;
        if (i_valid) begin
            unique case (i_probe.cmd)
                kpsb_pkg::CMD_CLEAR: begin
                    n_seq = kpsb_pkg::SEQ_EMPTY;
                end
                kpsb_pkg::CMD_INSERT: begin
                    if (!i_probe.done && !occupied) begin
                        n_seq        = i_probe.seq;
                        wr_en        = 1'b1;
                        n_probe.done = 1'b1;
                    end
                end
                kpsb_pkg::CMD_FIND: begin
                    if (!i_probe.done && hit) begin
                        n_probe.done  = 1'b1;
                        n_probe.seq   = r_seq;
                        n_probe.flags = r_flags;
                        n_probe.hdr   = r_hdr;
                    end
                end
                kpsb_pkg::CMD_REMOVE: begin
                    if (r_seq == i_probe.seq) begin
                        n_seq = kpsb_pkg::SEQ_EMPTY;
                    end
                end
                default: begin
                    n_seq = r_seq;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= kpsb_pkg::SEQ_EMPTY;
            r_valid <= 1'b0;
        end else begin
            r_seq   <= n_seq;
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        if (wr_en) begin
            r_flags <= i_probe.flags;
            r_hdr   <= i_probe.hdr;
        end
    end

    assign o_valid = r_valid;
    assign o_probe = r_probe;

endmodule

`default_nettype wire

// ===== rtl/keyed_packet_slot_buffer.sv =====
// Top level: packet header slot table built as a row of slot cells.
//
//  channel   handshake            fields
//  command   start / busy         i_command, i_seq_number, i_flag_value, i_packet_ident,
//                                 i_window_value, i_check_value, i_payload_length,
//                                 i_payload_handle
//  result    o_strobe             o_success, o_found_seq, o_found_flags, o_found_ident,
//                                 o_found_window, o_found_check, o_found_length,
//                                 o_found_handle
//
// A command enters slot 0 at the accepting edge and moves one slot per cycle; the result
// shows for one cycle, as the command leaves the last slot.
// busy stays high from the accepting edge through the result cycle, so a new command is
// accepted only after the result of the last one has shown.
// Synchronous reset empties every slot at once; no clearing pass is needed.
// The receiver cannot stall the result.
`default_nettype none

module keyed_packet_slot_buffer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  i_command,
    input  wire logic signed [15:0] i_seq_number,
    input  wire logic signed [8:0]  i_flag_value,
    input  wire logic signed [15:0] i_packet_ident,
    input  wire logic signed [15:0] i_window_value,
    input  wire logic signed [31:0] i_check_value,
    input  wire logic        [15:0] i_payload_length,
    input  wire logic        [15:0] i_payload_handle,
    output logic                    o_strobe,
    output logic                    o_success,
    output logic signed [15:0]      o_found_seq,
    output logic signed [8:0]       o_found_flags,
    output logic signed [15:0]      o_found_ident,
    output logic signed [15:0]      o_found_window,
    output logic signed [31:0]      o_found_check,
    output logic        [15:0]      o_found_length,
    output logic        [15:0]      o_found_handle
);

    logic                                 r_busy;
    logic                                 accept;
    logic             [kpsb_pkg::SLOT_COUNT:0] valid;
    kpsb_pkg::t_probe                     probe [0:kpsb_pkg::SLOT_COUNT];
    kpsb_pkg::t_probe                     last;
    logic                                 found;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    assign valid[0]         = accept;
    assign probe[0].cmd     = kpsb_pkg::t_cmd'(i_command);
    assign probe[0].seq     = i_seq_number;
    assign probe[0].flags   = i_flag_value;
    assign probe[0].hdr     = '{ident:  i_packet_ident,
                                window: i_window_value,
                                check:  i_check_value,
                                length: i_payload_length,
                                handle: i_payload_handle};
    assign probe[0].done    = 1'b0;

    for (genvar g = 0; g < kpsb_pkg::SLOT_COUNT; g++) begin : g_cell
        kpsb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[g]),
            .i_probe (probe[g]),
            .o_valid (valid[g+1]),
            .o_probe (probe[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (valid[kpsb_pkg::SLOT_COUNT]) begin
            r_busy <= 1'b0;
        end
    end

    assign last  = probe[kpsb_pkg::SLOT_COUNT];
    assign found = (last.cmd == kpsb_pkg::CMD_FIND) && last.done;

    assign o_strobe = valid[kpsb_pkg::SLOT_COUNT];

    always_comb begin
        unique case (last.cmd) inside
            kpsb_pkg::CMD_INSERT,
            kpsb_pkg::CMD_FIND: o_success = last.done;
            default:            o_success = 1'b1;
        endcase
    end

    // Anything but a find hit reports an empty slot.
    assign o_found_seq    = found ? last.seq        : kpsb_pkg::SEQ_EMPTY;
    assign o_found_flags  = found ? last.flags      : '0;
    assign o_found_ident  = found ? last.hdr.ident  : '0;
    assign o_found_window = found ? last.hdr.window : '0;
    assign o_found_check  = found ? last.hdr.check  : '0;
    assign o_found_length = found ? last.hdr.length : '0;
    assign o_found_handle = found ? last.hdr.handle : '0;

    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(valid[kpsb_pkg::SLOT_COUNT:1]))
        else $error("more than one command word in the cell row");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (valid[kpsb_pkg::SLOT_COUNT:1] == '0))
        else $error("command word in flight while idle");

    a_busy_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (valid[kpsb_pkg::SLOT_COUNT:1] != '0))
        else $error("busy with no command word in flight");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> valid[1] && r_busy)
        else $error("accepted command did not enter slot 0");

endmodule

`default_nettype wire
